FILE: sv/optics_polynomial_reconstruction_unit_defines.svh
// Assertion macros shared by the optics reconstruction RTL
`ifndef OPTICS_POLYNOMIAL_RECONSTRUCTION_UNIT_DEFINES_SVH
`define OPTICS_POLYNOMIAL_RECONSTRUCTION_UNIT_DEFINES_SVH

`define OPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define OPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/opr_pkg.sv
// ----------------------------------------------------------------------------
// opr_pkg
// Shared widths, codes, limits and the table write type for the reconstruction
// datapath.
// ----------------------------------------------------------------------------
package opr_pkg;

  localparam int COEF_W  = 48;
  localparam int POS_W   = 32;
  localparam int PWR_W   = 15;
  localparam int EXP_W   = 3;
  localparam int NVAR    = 5;
  localparam int FIX_SH  = 30;
  localparam int CFG_W   = 10;
  localparam int SLOT_W  = 9;
  localparam int PROD_W  = 48;
  localparam int FACT_W  = 34;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(64'd1 << FIX_SH);
  localparam logic [47:0] PROD_LIM = {1'b0, {47{1'b1}}};
  localparam logic [48:0] CONTRIB_LIM = {1'b1, 48'd0};

  typedef struct packed {
    logic                     we;
    logic [SLOT_W-1:0]        slot;
    logic [4*COEF_W+PWR_W-1:0] data;
  } tbl_wr_t;

endpackage

FILE: sv/opr_mul.sv
// ----------------------------------------------------------------------------
// opr_mul
// Three-stage signed 48x48 multiply, rounded by 2^30 with ties away from zero,
// magnitude saturated to a limit. The two 24x48 partial products are formed in the first and second stages.
// ----------------------------------------------------------------------------
module opr_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [47:0] a,
  input  logic [47:0] b,
  input  logic [48:0] lim,
  output logic        out_vld,
  output logic [49:0] res
);

  logic [47:0] ma, mb;
  logic [71:0] plo_r;
  logic [23:0] mah_r;
  logic [47:0] mb_r;
  logic [95:0] prod_r;
  logic        neg_r, neg2_r, v1_r, v2_r, v3_r;
  logic [48:0] lim_r, lim2_r;
  logic [95:0] rnd;
  logic [65:0] q;
  logic [48:0] m;
  logic [49:0] res_r;

  assign ma = a[47] ? (~a + 48'd1) : a;
  assign mb = b[47] ? (~b + 48'd1) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    plo_r  <= 72'(ma[23:0]) * 72'(mb);
    mah_r  <= ma[47:24];
    mb_r   <= mb;
    neg_r  <= a[47] ^ b[47];
    lim_r  <= lim;
    prod_r <= 96'(plo_r) + (96'(72'(mah_r) * 72'(mb_r)) << 24);
    neg2_r <= neg_r;
    lim2_r <= lim_r;
    res_r  <= neg2_r ? (~{1'b0, m} + 50'd1) : {1'b0, m};
  end

  assign rnd = prod_r + (96'd1 << (opr_pkg::FIX_SH - 1));
  assign q   = rnd[95:opr_pkg::FIX_SH];
  assign m   = (q > 66'(lim2_r)) ? lim2_r : q[48:0];

  assign res     = res_r;
  assign out_vld = v3_r;

endmodule

FILE: sv/opr_table.sv
// ----------------------------------------------------------------------------
// opr_table
// Term table: one synchronous memory holding four coefficients and exponents.
// ----------------------------------------------------------------------------
module opr_table #(
  parameter int MAX_TERMS = 512,
  parameter int AW = 9
) (
  input  logic                                  clk,
  input  opr_pkg::tbl_wr_t                      wr,
  input  logic [AW-1:0]                         rd_addr,
  output logic [4*opr_pkg::COEF_W+opr_pkg::PWR_W-1:0] rd_data
);

  logic [4*opr_pkg::COEF_W+opr_pkg::PWR_W-1:0] mem [MAX_TERMS];
  logic [4*opr_pkg::COEF_W+opr_pkg::PWR_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr.we && (32'(wr.slot) < 32'(MAX_TERMS))) begin
      mem[AW'(wr.slot)] <= wr.data;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

FILE: sv/opr_pos.sv
// ----------------------------------------------------------------------------
// opr_pos
// Cm to metre conversion: round(raw*128/100) = floor((32*|raw| + 12) / 25),
// the divide done as a reciprocal multiply through registers num_r, plo_r and quo_r.
// ----------------------------------------------------------------------------
module opr_pos (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] raw,
  output logic        done,
  output logic [33:0] q
);

  // ceil(2^42 / 25), exact for numerators below 2^37
  localparam logic [37:0] RECIP = 38'h28F5C28F5D;

  logic [31:0] mag;
  logic [36:0] num_r, num2_r;
  logic [55:0] plo_r;
  logic [74:0] prod;
  logic [32:0] quo_r;
  logic        neg_r, neg2_r, neg3_r, s1_r, s2_r, done_r;

  assign mag = raw[31] ? (~raw + 32'd1) : raw;

  assign prod = 75'(plo_r) + (75'(56'(num2_r) * 56'(RECIP[37:19])) << 19);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
    if (start) begin
      num_r <= {mag, 5'd0} + 37'd12;
      neg_r <= raw[31];
    end
    plo_r  <= 56'(num_r) * 56'(RECIP[18:0]);
    num2_r <= num_r;
    neg2_r <= neg_r;
    quo_r  <= prod[74:42];
    neg3_r <= neg2_r;
  end

  assign q    = neg3_r ? (~{1'b0, quo_r} + 34'd1) : {1'b0, quo_r};
  assign done = done_r;

endmodule

FILE: sv/optics_polynomial_reconstruction_unit.sv
// Per event, before its result strobe: the three position conversions, then for each active
// term E exponent products (E being the term's clamped exponent sum) and four coefficient
// products; one shared rounding multiplier does them all, reading one term at a time.
// A load is written at its accepting edge and busy stays low: one load per cycle while busy is low.
// Throughput: one event at a time; busy is high through the one-cycle result strobe.
// Reset: synchronous active-low; clears control and active_terms, not the table.
// ----------------------------------------------------------------------------
// optics_polynomial_reconstruction_unit
// Polynomial reconstruction of target quantities from focal-plane words.
// ----------------------------------------------------------------------------
`include "optics_polynomial_reconstruction_unit_defines.svh"

module optics_polynomial_reconstruction_unit #(
  parameter int MAX_TERMS = 512,
  parameter int MAX_POWER = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_active_terms,
  input  logic               in_req_type,
  input  logic [8:0]         in_term_slot,
  input  logic signed [47:0] in_coef_delta,
  input  logic signed [47:0] in_coef_ytar,
  input  logic signed [47:0] in_coef_yptar,
  input  logic signed [47:0] in_coef_xptar,
  input  logic [14:0]        in_term_powers,
  input  logic signed [31:0] in_focal_x,
  input  logic signed [31:0] in_focal_y,
  input  logic signed [31:0] in_focal_x_slope,
  input  logic signed [31:0] in_focal_y_slope,
  input  logic signed [31:0] in_target_x,
  output logic               out_valid,
  output logic signed [47:0] out_delta_recon,
  output logic signed [47:0] out_ytar_recon,
  output logic signed [47:0] out_yptar_recon,
  output logic signed [47:0] out_xptar_recon
);

  localparam int AW  = $clog2(MAX_TERMS);
  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int TW  = 4*opr_pkg::COEF_W + opr_pkg::PWR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_RD, S_RDW, S_EXP, S_MWAIT, S_COEF, S_CWAIT, S_NEXT, S_OUT
  } state_t;

  state_t state_r;
  logic [9:0]  act_r;
  logic [CW-1:0] n_r, i_r;
  logic [2:0]  var_r, ecnt_r, cix_r, cgot_r;
  logic [47:0] f_r [opr_pkg::NVAR];
  logic [47:0] p_r;
  logic [TW-1:0] ent_r;
  logic [47:0] acc_r [4];
  logic        out_v_r;

  opr_pkg::tbl_wr_t wr;
  logic [TW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic        m_in_v, m_out_v;
  logic [47:0] m_a, m_b;
  logic [48:0] m_lim;
  logic [49:0] m_res;

  logic        pos_start;
  logic [31:0] pos_raw [3];
  logic        pos_done [3];
  logic [33:0] pos_q [3];

  logic [2:0]  e_raw, e_cl;
  logic [3:0]  e_off;
  logic [47:0] coef_sel;
  logic [49:0] sum;
  logic [47:0] sat;
  logic [CW-1:0] lim_n;

  assign wr.we   = start && !busy && (in_req_type == opr_pkg::REQ_LOAD);
  assign wr.slot = in_term_slot;
  assign wr.data = {in_term_powers, in_coef_xptar, in_coef_yptar, in_coef_ytar, in_coef_delta};
  assign rd_addr = i_r[AW-1:0];

  opr_table #(.MAX_TERMS(MAX_TERMS), .AW(AW)) u_tbl (
    .clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign pos_start  = start && !busy && (in_req_type == opr_pkg::REQ_EVENT);
  assign pos_raw[0] = in_focal_x;
  assign pos_raw[1] = in_focal_y;
  assign pos_raw[2] = in_target_x;

  for (genvar g = 0; g < 3; g++) begin : g_pos
    opr_pos u_pos (
      .clk(clk), .rst_n(rst_n), .start(pos_start), .raw(pos_raw[g]),
      .done(pos_done[g]), .q(pos_q[g])
    );
  end

  opr_mul u_mul (
    .clk(clk), .rst_n(rst_n), .in_vld(m_in_v), .a(m_a), .b(m_b), .lim(m_lim),
    .out_vld(m_out_v), .res(m_res)
  );

  // order xfp, yfp, xpfp, ypfp, xtar; exponent offsets 0, 6, 3, 9, 12
  always_comb begin
    case (var_r)
      3'd0:    e_off = 4'd0;
      3'd1:    e_off = 4'd6;
      3'd2:    e_off = 4'd3;
      3'd3:    e_off = 4'd9;
      default: e_off = 4'd12;
    endcase
  end
  assign e_raw = 3'(ent_r[4*opr_pkg::COEF_W + 32'(e_off) +: 3]);
  assign e_cl  = (32'(e_raw) > MAX_POWER) ? 3'(MAX_POWER) : e_raw;
  assign coef_sel = ent_r[48*32'(cix_r[1:0]) +: 48];
  assign lim_n = (32'(act_r) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(act_r);

  assign m_in_v = (state_r == S_EXP && ecnt_r < e_cl && var_r < 3'd5) ||
                  (state_r == S_COEF && cix_r < 3'd4);
  assign m_a    = (state_r == S_COEF) ? coef_sel : p_r;
  assign m_b    = (state_r == S_COEF) ? p_r : f_r[var_r];
  assign m_lim  = (state_r == S_COEF) ? opr_pkg::CONTRIB_LIM : {1'b0, opr_pkg::PROD_LIM};

  assign sum = {{2{acc_r[cgot_r[1:0]][47]}}, acc_r[cgot_r[1:0]]} + m_res;
  always_comb begin
    if ($signed(sum) > $signed({2'b00, opr_pkg::PROD_LIM})) sat = opr_pkg::PROD_LIM;
    else if ($signed(sum) < $signed({3'b111, 47'd0})) sat = {1'b1, 47'd0};
    else sat = sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      if (cfg_we) act_r <= cfg_active_terms;
      // coefficient products start arriving while still in S_COEF
      if (m_out_v && (state_r == S_COEF || state_r == S_CWAIT)) begin
        acc_r[cgot_r[1:0]] <= sat;
        cgot_r <= cgot_r + 3'd1;
      end
      case (state_r)
        S_IDLE: begin
          if (pos_start) begin
            f_r[2]  <= {{16{in_focal_x_slope[31]}}, in_focal_x_slope};
            f_r[3]  <= {{16{in_focal_y_slope[31]}}, in_focal_y_slope};
            n_r     <= lim_n;
            acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0; acc_r[3] <= '0;
            state_r <= S_POS;
          end
        end
        S_POS: begin
          if (pos_done[0] && pos_done[1] && pos_done[2]) begin
            f_r[0] <= {{14{pos_q[0][33]}}, pos_q[0]};
            f_r[1] <= {{14{pos_q[1][33]}}, pos_q[1]};
            f_r[4] <= {{14{pos_q[2][33]}}, pos_q[2]};
            i_r    <= '0;
            state_r <= (n_r == '0) ? S_OUT : S_RD;
          end
        end
        S_RD:  state_r <= S_RDW;
        S_RDW: begin
          ent_r  <= rd_data;
          p_r    <= opr_pkg::PROD_ONE;
          var_r  <= '0;
          ecnt_r <= '0;
          state_r <= S_EXP;
        end
        S_EXP: begin
          if (var_r == 3'd5) begin
            cix_r <= '0; cgot_r <= '0;
            state_r <= S_COEF;
          end else if (ecnt_r < e_cl) begin
            state_r <= S_MWAIT;
          end else begin
            var_r <= var_r + 3'd1;
            ecnt_r <= '0;
          end
        end
        S_MWAIT: begin
          if (m_out_v) begin
            p_r <= m_res[47:0];
            ecnt_r <= ecnt_r + 3'd1;
            state_r <= S_EXP;
          end
        end
        S_COEF: begin
          cix_r <= cix_r + 3'd1;
          if (cix_r == 3'd3) state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (m_out_v && cgot_r == 3'd3) state_r <= S_NEXT;
        end
        S_NEXT: begin
          i_r <= i_r + CW'(1);
          state_r <= (i_r + CW'(1) == n_r) ? S_OUT : S_RD;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE) || out_v_r;
  assign out_valid       = out_v_r;
  assign out_delta_recon = acc_r[0];
  assign out_ytar_recon  = acc_r[1];
  assign out_yptar_recon = acc_r[2];
  assign out_xptar_recon = acc_r[3];

  `OPR_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE, "result outside idle")
  `OPR_ASSERT_NXT(a_busy_after, clk, rst_n, pos_start, busy, "busy not raised")
  `OPR_ASSERT_IMP(a_idx, clk, rst_n, state_r == S_RD, i_r < n_r, "term index past count")

endmodule
